>>> hw/rtl/adrc_pkg.sv
// ----------------------------------------------------------------------------
// adrc_pkg
// Shared types and constants of the audio dynamic range compressor.
// ----------------------------------------------------------------------------
package adrc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int COEF_W     = 24;
    localparam int DB_W       = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_POWER_COEFF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_DB  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_RATIO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEFF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_GAIN    = 3'd5;

    // dB per octave of power (10*log10(2), Q.16) and log2(10)/20 (Q.24)
    localparam logic [31:0] DB_PER_LOG2_Q16   = 32'd197283;
    localparam logic [31:0] LOG2_10_DIV20_Q24 = 32'd2786559;
    // deepest target attenuation, magnitude in Q8.8
    localparam logic [23:0] DB_FLOOR_MAG      = 24'd33280;

    // 2^(-2^-(k+1)) in Q.16
    localparam logic [15:0] EXP_TAB [16] = '{
        16'd46341, 16'd55109, 16'd60097, 16'd62757,
        16'd64132, 16'd64830, 16'd65182, 16'd65359,
        16'd65447, 16'd65492, 16'd65514, 16'd65525,
        16'd65530, 16'd65533, 16'd65535, 16'd65535
    };

    typedef struct packed {
        logic [COEF_W-1:0]      power_coeff;
        logic signed [DB_W-1:0] threshold_db;
        logic [16:0]            inverse_ratio;
        logic [COEF_W-1:0]      attack_coeff;
        logic [COEF_W-1:0]      release_coeff;
        logic [15:0]            boost_gain;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQ,
        OP_P1,
        OP_P2,
        OP_NORM,
        OP_LOG,
        OP_LVL,
        OP_TGT,
        OP_G1,
        OP_G2,
        OP_EXP,
        OP_GAIN,
        OP_SHIFT,
        OP_BOOST,
        OP_Y1,
        OP_Y2
    } t_op;

    // datapath step and the loop index of the log and exp steps
    typedef struct packed {
        t_op        op;
        logic [3:0] k;
    } t_cmd;

endpackage

>>> hw/rtl/adrc_cfg.sv
// ----------------------------------------------------------------------------
// adrc_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module adrc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [adrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [adrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output adrc_pkg::t_cfg                  o_cfg
);
    import adrc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_coeff   <= 24'd16568810;
            r_cfg.threshold_db  <= -17'sd2677;
            r_cfg.inverse_ratio <= 17'd16384;
            r_cfg.attack_coeff  <= 24'd16568810;
            r_cfg.release_coeff <= 24'd16771973;
            r_cfg.boost_gain    <= 16'd4096;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_POWER_COEFF:   r_cfg.power_coeff   <= i_cfg_data[COEF_W-1:0];
                CFG_THRESHOLD_DB:  r_cfg.threshold_db  <= $signed(i_cfg_data[DB_W-1:0]);
                CFG_INVERSE_RATIO: r_cfg.inverse_ratio <= i_cfg_data[16:0];
                CFG_ATTACK_COEFF:  r_cfg.attack_coeff  <= i_cfg_data[COEF_W-1:0];
                CFG_RELEASE_COEFF: r_cfg.release_coeff <= i_cfg_data[COEF_W-1:0];
                CFG_BOOST_GAIN:    r_cfg.boost_gain    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/adrc_ctrl.sv
// ----------------------------------------------------------------------------
// adrc_ctrl
// Sequencer: steps the datapath through one sample and runs the handshakes.
// ----------------------------------------------------------------------------
module adrc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic                i_norm_done,
    output adrc_pkg::t_cmd      o_cmd
);
    import adrc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_P1, S_P2, S_NORM, S_LOG, S_LVL, S_TGT,
        S_G1, S_G2, S_EXP, S_GAIN, S_SHIFT, S_BOOST, S_Y1, S_Y2
    } t_state;

    t_state     r_state;
    logic [3:0] r_cnt;
    logic       r_out_valid;
    logic       y2_fire;

    // final step waits until the previous result has left the output register
    assign y2_fire = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.k = r_cnt;
        unique case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NOP;
            S_SQ:    o_cmd.op = OP_SQ;
            S_P1:    o_cmd.op = OP_P1;
            S_P2:    o_cmd.op = OP_P2;
            S_NORM:  o_cmd.op = OP_NORM;
            S_LOG:   o_cmd.op = OP_LOG;
            S_LVL:   o_cmd.op = OP_LVL;
            S_TGT:   o_cmd.op = OP_TGT;
            S_G1:    o_cmd.op = OP_G1;
            S_G2:    o_cmd.op = OP_G2;
            S_EXP:   o_cmd.op = OP_EXP;
            S_GAIN:  o_cmd.op = OP_GAIN;
            S_SHIFT: o_cmd.op = OP_SHIFT;
            S_BOOST: o_cmd.op = OP_BOOST;
            S_Y1:    o_cmd.op = OP_Y1;
            S_Y2:    o_cmd.op = y2_fire ? OP_Y2 : OP_NOP;
            default: o_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_SQ;
                end
                S_SQ:  r_state <= S_P1;
                S_P1:  r_state <= S_P2;
                S_P2:  r_state <= S_NORM;
                S_NORM: begin
                    if (i_norm_done) begin
                        r_cnt   <= '0;
                        r_state <= S_LOG;
                    end
                end
                S_LOG: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (&r_cnt) r_state <= S_LVL;
                end
                S_LVL: r_state <= S_TGT;
                S_TGT: r_state <= S_G1;
                S_G1:  r_state <= S_G2;
                S_G2:  r_state <= S_EXP;
                S_EXP: begin
                    r_cnt   <= '0;
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (&r_cnt) r_state <= S_SHIFT;
                end
                S_SHIFT: r_state <= S_BOOST;
                S_BOOST: r_state <= S_Y1;
                S_Y1:    r_state <= S_Y2;
                S_Y2: begin
                    if (y2_fire) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/adrc_dp.sv
// ----------------------------------------------------------------------------
// adrc_dp
// Datapath: one shared 32x32 multiplier, filter state, log and exp steps.
// ----------------------------------------------------------------------------
module adrc_dp #(
    parameter int SAMPLE_BITS     = 16,
    parameter int COEFF_FRAC_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  adrc_pkg::t_cmd                i_cmd,
    input  adrc_pkg::t_cfg                i_cfg,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    output logic                          o_norm_done,
    output logic [SAMPLE_BITS-1:0]        o_sample,
    output logic [adrc_pkg::DB_W-1:0]     o_gain_db
);
    import adrc_pkg::*;

    localparam int CF = COEFF_FRAC_BITS;
    localparam int CW = CF + 1;
    localparam logic [63:0] ONE  = 64'd1 << CF;
    localparam logic [63:0] HALF = 64'd1 << (CF - 1);
    // power is Q1.30; squared sample carries 2*(SAMPLE_BITS-1) fraction bits
    localparam int SH  = 2 * (SAMPLE_BITS - 1) - 30;
    localparam int SHR = (SH > 0) ? SH : 0;
    localparam int SHL = (SH < 0) ? -SH : 0;
    localparam logic [63:0] SQ_RND = (SH > 0) ? (64'd1 << SHR) >> 1 : 64'd0;
    localparam logic [63:0] PWR_ONE = 64'd1 << 30;
    localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    function automatic logic [CW-1:0] clamp_c(input logic [COEF_W-1:0] c);
        if (64'(c) > ONE) return ONE[CW-1:0];
        else return CW'(c);
    endfunction

    logic [SAMPLE_BITS-1:0] r_mag;
    logic                   r_neg;
    logic [30:0]            r_x;
    logic [30:0]            r_pwr;
    logic [63:0]            r_acc;
    logic [30:0]            r_m;
    logic [4:0]             r_z;
    logic [15:0]            r_frac;
    logic [14:0]            r_lmag;
    logic [23:0]            r_tm;
    logic [23:0]            r_gm;
    logic [20:0]            r_ex;
    logic [30:0]            r_gain;
    logic [33:0]            r_gb;
    logic [SAMPLE_BITS-1:0] r_out_s;
    logic [DB_W-1:0]        r_out_g;

    logic [31:0]      mul_a, mul_b;
    logic [63:0]      prod;
    logic [CW-1:0]    c_pwr, c_gain, omc_pwr, omc_gain;
    logic [20:0]      negl;
    logic signed [19:0] ovr, dr;
    logic [19:0]      ovr_mag, dr_mag;
    logic             tgt_neg;
    logic [63:0]      sq_s, p_sum, g_sum, y_sum, tmag;
    logic [30:0]      p_new;
    logic [31:0]      q;
    logic [63:0]      ym;
    logic [4:0]       n_sh;
    logic [16:0]      gdb_mag;

    assign c_pwr    = clamp_c(i_cfg.power_coeff);
    assign c_gain   = clamp_c((r_tm > r_gm) ? i_cfg.attack_coeff : i_cfg.release_coeff);
    assign omc_pwr  = ONE[CW-1:0] - c_pwr;
    assign omc_gain = ONE[CW-1:0] - c_gain;
    assign negl     = {r_z, 16'd0} - 21'(r_frac);

    // over = level - threshold, slope = inverse_ratio - 1, done on magnitudes
    assign ovr     = -$signed({5'd0, r_lmag}) - 20'($signed(i_cfg.threshold_db));
    assign dr      = $signed({3'd0, i_cfg.inverse_ratio}) - 20'sd65536;
    assign ovr_mag = ovr[19] ? 20'(-ovr) : 20'(ovr);
    assign dr_mag  = dr[19] ? 20'(-dr) : 20'(dr);
    assign tgt_neg = ovr[19] ^ dr[19];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_SQ:    begin mul_a = 32'(r_mag);    mul_b = 32'(r_mag);            end
            OP_P1:    begin mul_a = 32'(c_pwr);    mul_b = 32'(r_pwr);            end
            OP_P2:    begin mul_a = 32'(omc_pwr);  mul_b = 32'(r_x);              end
            OP_LOG:   begin mul_a = 32'(r_m);      mul_b = 32'(r_m);              end
            OP_LVL:   begin mul_a = 32'(negl);     mul_b = DB_PER_LOG2_Q16;       end
            OP_TGT:   begin mul_a = 32'(ovr_mag);  mul_b = 32'(dr_mag);           end
            OP_G1:    begin mul_a = 32'(c_gain);   mul_b = 32'(r_gm);             end
            OP_G2:    begin mul_a = 32'(omc_gain); mul_b = 32'(r_tm);             end
            OP_EXP:   begin mul_a = 32'(r_gm);     mul_b = LOG2_10_DIV20_Q24;     end
            OP_GAIN:  begin mul_a = 32'(r_gain);   mul_b = 32'(EXP_TAB[i_cmd.k]); end
            OP_BOOST: begin mul_a = 32'(r_gain);   mul_b = 32'(i_cfg.boost_gain); end
            OP_Y1:    begin mul_a = 32'(r_mag);    mul_b = 32'(r_gb[17:0]);       end
            OP_Y2:    begin mul_a = 32'(r_mag);    mul_b = 32'(r_gb[33:18]);      end
            default:  begin mul_a = '0;            mul_b = '0;                    end
        endcase
    end

    assign prod  = 64'(mul_a) * 64'(mul_b);
    assign sq_s  = ((prod + SQ_RND) >> SHR) << SHL;
    assign p_sum = r_acc + prod + HALF;
    assign p_new = 31'(p_sum >> CF);
    assign g_sum = r_acc + prod + HALF;
    assign q     = prod[61:30];
    assign tmag  = (prod + 64'd32768) >> 16;
    assign y_sum = r_acc + (prod << 18) + (64'd1 << 29);
    assign ym    = y_sum >> 30;
    assign n_sh  = r_ex[20:16];
    assign gdb_mag = 17'((25'(r_gm) + 25'd128) >> 8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwr <= 31'd1 << 30;
            r_gm  <= '0;
        end else begin
            case (i_cmd.op)
                OP_P2: begin
                    r_pwr <= (p_new == '0) ? 31'd1 : p_new;
                end
                OP_G2: begin
                    r_gm <= 24'(g_sum >> CF);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_neg <= i_sample[SAMPLE_BITS-1];
                r_mag <= i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
            end
            OP_SQ: begin
                r_x <= (sq_s > PWR_ONE) ? PWR_ONE[30:0] : sq_s[30:0];
            end
            OP_P1: r_acc <= prod;
            OP_P2: begin
                r_m    <= (p_new == '0) ? 31'd1 : p_new;
                r_z    <= '0;
                r_frac <= '0;
            end
            OP_NORM: begin
                if (!r_m[30]) begin
                    r_m <= {r_m[29:0], 1'b0};
                    r_z <= r_z + 5'd1;
                end
            end
            OP_LOG: begin
                r_frac <= {r_frac[14:0], q[31]};
                r_m    <= q[31] ? q[31:1] : q[30:0];
            end
            OP_LVL: r_lmag <= 15'((prod + (64'd1 << 23)) >> 24);
            OP_TGT: begin
                if (!tgt_neg) r_tm <= '0;
                else if (tmag > 64'(DB_FLOOR_MAG)) r_tm <= DB_FLOOR_MAG << 8;
                else r_tm <= {tmag[15:0], 8'd0};
            end
            OP_G1: r_acc <= prod;
            OP_EXP: begin
                r_ex   <= 21'((prod + (64'd1 << 23)) >> 24);
                r_gain <= 31'd1 << 30;
            end
            OP_GAIN: begin
                if (r_ex[4'd15 - i_cmd.k]) r_gain <= 31'((prod + 64'd32768) >> 16);
            end
            OP_SHIFT: r_gain <= (&n_sh) ? '0 : (r_gain >> n_sh);
            OP_BOOST: r_gb <= 34'((prod + 64'd2048) >> 12);
            OP_Y1: r_acc <= prod;
            OP_Y2: begin
                if (r_neg) begin
                    r_out_s <= (ym > 64'(SMIN)) ? SMIN : (~ym[SAMPLE_BITS-1:0] + 1'b1);
                end else begin
                    r_out_s <= (ym > 64'(SMAX)) ? SMAX : ym[SAMPLE_BITS-1:0];
                end
                r_out_g <= ~gdb_mag + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_norm_done = r_m[30];
    assign o_sample    = r_out_s;
    assign o_gain_db   = r_out_g;

endmodule

>>> hw/rtl/audio_dynamic_range_compressor.sv
// ----------------------------------------------------------------------------
// audio_dynamic_range_compressor
// Feed-forward compressor with power detector, dB gain law, attack/release.
// ----------------------------------------------------------------------------
// One sample in, one compressed sample and its applied gain (Q8.8 dB) out.
// Samples are processed one at a time through a shared 32x32 multiplier:
// the time from acceptance to result is set mainly by the leading-one
// search on the smoothed power (one bit a cycle), the 16 squaring steps of
// the log and the 16 table steps of the exp. The output register holds a
// finished result while the next sample is taken in; the last step waits
// for it to be taken. Registers are written through the plain write port;
// the user must write them only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module audio_dynamic_range_compressor #(
    parameter int SAMPLE_BITS     = 16,
    parameter int COEFF_FRAC_BITS = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [adrc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [adrc_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: sample_in
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // tdata: sample_out, applied_gain_db
    output logic [((SAMPLE_BITS+17+7)/8)*8-1:0]     m_axis_tdata
);
    import adrc_pkg::*;

    localparam int OUT_W = ((SAMPLE_BITS + 17 + 7) / 8) * 8;

    t_cfg                   cfg;
    t_cmd                   cmd;
    logic                   norm_done;
    logic [SAMPLE_BITS-1:0] out_sample;
    logic [DB_W-1:0]        out_gain;

    adrc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    adrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_norm_done (norm_done),
        .o_cmd       (cmd)
    );

    adrc_dp #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_norm_done (norm_done),
        .o_sample    (out_sample),
        .o_gain_db   (out_gain)
    );

    assign m_axis_tdata = OUT_W'({out_gain, out_sample});

endmodule
